@@ sv/mcwd_pkg.sv @@
// ----------------------------------------------------------------------------
// mcwd_pkg
// Shared types and codes for the multi-channel watchdog pool.
// ----------------------------------------------------------------------------
`default_nettype none
package mcwd_pkg;
  localparam int CHANNELS_DEF = 16;

  typedef enum logic [3:0] {
    K_INIT = 4'd0, K_START = 4'd1, K_STOP = 4'd2, K_PAUSE = 4'd3,
    K_RESTART = 4'd4, K_PET = 4'd5, K_FORCE = 4'd6, K_ROUTINE = 4'd7,
    K_ENABLE = 4'd8, K_DISABLE = 4'd9
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_ERROR = 3'd1, ST_NOT_RUNNING = 3'd2, ST_TIMED_OUT = 3'd3,
    ST_TIME_BACK = 3'd4, ST_DISABLED = 3'd5, ST_UNINIT = 3'd6, ST_BUSY = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    M_IDLE = 2'd0, M_RUN = 2'd1, M_PAUSE = 2'd2, M_DONE = 2'd3
  } mode_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  channel;
    logic [31:0] now;
    logic [31:0] timeout_ticks;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       fired;
    logic [3:0] fired_channel;
    logic [1:0] channel_mode;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SCAN, S_FIRE, S_SHIFT, S_FINAL
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item
    logic exec;       // run single-channel command
    logic scan_clr;   // clear scan candidate
    logic scan_step;  // examine one channel
    logic fire;       // mark best candidate timed out, emit fired
    logic shift_step; // shift one running deadline
    logic fin;        // emit final result
    logic scan_done;  // routine finished: update last tick
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_routine;
    logic go_scan;    // routine passes checks
    logic go_shift;   // enable passes and pool was off
    logic go_force;   // force_timeout passes
    logic found;      // scan has a candidate, including the channel under test
    logic idx_last;   // scan index at final channel
  } stat_t;
endpackage
`default_nettype wire

@@ sv/mcwd_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcwd_ctrl
// Command sequencer: exec, deadline scan / fire loop, enable shift, final.
// ----------------------------------------------------------------------------
`default_nettype none
module mcwd_ctrl
  import mcwd_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_ready,
  input  wire  out_busy,   // output register still holds an untaken result
  output logic out_load,
  output cmd_t cmd,
  input  stat_t st
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: begin
        if (st.go_force) state_next = S_FIRE;
        else if (st.go_scan || st.go_shift) state_next = st.is_routine ? S_SCAN : S_SHIFT;
        else state_next = S_FINAL;
      end
      S_SCAN: if (st.idx_last) state_next = st.found ? S_FIRE : S_FINAL;
      S_FIRE: if (!out_busy) state_next = st.is_routine ? S_SCAN : S_FINAL;
      S_SHIFT: if (st.idx_last) state_next = S_FINAL;
      S_FINAL: if (!out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.scan_done = st.idx_last && !st.found;
      end
      S_FIRE: begin
        if (!out_busy) begin
          cmd.fire = 1'b1;
          out_load = 1'b1;
          cmd.scan_clr = 1'b1;
        end
      end
      S_SHIFT: cmd.shift_step = 1'b1;
      S_FINAL: begin
        if (!out_busy) begin
          cmd.fin = 1'b1;
          out_load = 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ sv/mcwd_dp.sv @@
// ----------------------------------------------------------------------------
// mcwd_dp
// Channel state, status checks, deadline scan and shift datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module mcwd_dp
  import mcwd_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire       clk,
  input  wire       rst,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output stat_t     st,
  output out_item_t res
);
  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  mode_t       chan_mode  [CHANNELS];
  logic        chan_ready [CHANNELS];
  logic [31:0] chan_timeout [CHANNELS];
  logic [31:0] chan_deadline [CHANNELS];
  logic [31:0] chan_mark [CHANNELS];
  logic [31:0] last_tick;
  logic        pool_on;

  in_item_t    cur;
  status_t     status;
  logic [IW-1:0] idx;
  logic [IW-1:0] best;
  logic        found;
  logic [31:0] best_dl;

  logic        valid_ch;
  logic [IW-1:0] ch;
  logic        back;
  mode_t       m;
  logic        rdy;
  status_t     st_c;
  logic        cand;

  assign valid_ch = ({28'd0, cur.channel} < 32'(CHANNELS));
  assign ch       = valid_ch ? IW'(cur.channel) : '0;
  assign back     = cur.now < last_tick;
  assign m        = chan_mode[ch];
  assign rdy      = chan_ready[ch];

  // status for the held command, checked in priority order
  always_comb begin
    st_c = ST_OK;
    if (cur.kind <= K_FORCE && !valid_ch) st_c = ST_ERROR;
    else begin
      case (cur.kind)
        K_INIT: if (rdy || cur.timeout_ticks == 32'd0) st_c = ST_ERROR;
        K_START: begin
          if (back) st_c = ST_TIME_BACK;
          else if (!rdy) st_c = ST_UNINIT;
          else if (!pool_on) st_c = ST_DISABLED;
          else if (m == M_RUN) st_c = ST_BUSY;
          else if (m == M_DONE) st_c = ST_TIMED_OUT;
        end
        K_STOP: begin
          if (!rdy) st_c = ST_UNINIT;
          else if (m == M_IDLE) st_c = ST_NOT_RUNNING;
          else if (m == M_DONE) st_c = ST_TIMED_OUT;
          else if (!pool_on) st_c = ST_DISABLED;
        end
        K_PAUSE: begin
          if (back) st_c = ST_TIME_BACK;
          else if (!rdy) st_c = ST_UNINIT;
          else if (m == M_DONE) st_c = ST_TIMED_OUT;
          else if (m != M_RUN) st_c = ST_NOT_RUNNING;
          else if (!pool_on) st_c = ST_DISABLED;
        end
        K_RESTART: begin
          if (!rdy) st_c = ST_UNINIT;
          else if (back) st_c = ST_TIME_BACK;
          else if (!pool_on) st_c = ST_DISABLED;
        end
        K_PET: begin
          if (!rdy) st_c = ST_UNINIT;
          else if (back) st_c = ST_TIME_BACK;
          else if (m == M_DONE) st_c = ST_TIMED_OUT;
          else if (m != M_RUN) st_c = ST_NOT_RUNNING;
          else if (!pool_on) st_c = ST_DISABLED;
        end
        K_FORCE: begin
          if (!rdy) st_c = ST_UNINIT;
          else if (m != M_RUN) st_c = ST_NOT_RUNNING;
          else if (!pool_on) st_c = ST_DISABLED;
        end
        K_ROUTINE: begin
          if (back) st_c = ST_TIME_BACK;
          else if (!pool_on) st_c = ST_DISABLED;
        end
        K_ENABLE, K_DISABLE: if (back) st_c = ST_TIME_BACK;
        default: st_c = ST_ERROR;
      endcase
    end
  end

  // scan candidate: running, deadline <= now, strictly smaller deadline wins
  assign cand = chan_mode[idx] == M_RUN && chan_deadline[idx] <= cur.now &&
                (!found || chan_deadline[idx] < best_dl);

  assign st.is_routine = (cur.kind == K_ROUTINE);
  assign st.go_scan    = (cur.kind == K_ROUTINE) && st_c == ST_OK;
  assign st.go_shift   = (cur.kind == K_ENABLE) && st_c == ST_OK && !pool_on;
  assign st.go_force   = (cur.kind == K_FORCE) && st_c == ST_OK;
  assign st.found      = found || cand;
  assign st.idx_last   = (32'(idx) == 32'(CHANNELS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        chan_mode[i]     <= M_IDLE;
        chan_ready[i]    <= 1'b0;
        chan_timeout[i]  <= '0;
        chan_deadline[i] <= '0;
        chan_mark[i]     <= '0;
      end
      last_tick <= '0;
      pool_on   <= 1'b0;
      found     <= 1'b0;
      idx       <= '0;
    end else begin
      if (cmd.load) cur <= in_item;
      if (cmd.scan_clr) begin
        found <= 1'b0;
        idx   <= '0;
      end
      if (cmd.exec) begin
        status <= st_c;
        if (st_c == ST_OK) begin
          case (cur.kind)
            K_INIT: begin
              chan_mode[ch]     <= M_IDLE;
              chan_timeout[ch]  <= cur.timeout_ticks;
              chan_deadline[ch] <= '0;
              chan_mark[ch]     <= '0;
              chan_ready[ch]    <= 1'b1;
            end
            K_START: begin
              chan_deadline[ch] <= (m == M_PAUSE) ?
                  cur.now + (chan_deadline[ch] - chan_mark[ch]) :
                  cur.now + chan_timeout[ch];
              chan_mode[ch] <= M_RUN;
            end
            K_STOP: chan_mode[ch] <= M_IDLE;
            K_PAUSE: begin
              chan_mode[ch] <= M_PAUSE;
              chan_mark[ch] <= cur.now;
            end
            K_RESTART: begin
              chan_mark[ch]     <= cur.now;
              chan_deadline[ch] <= cur.now + chan_timeout[ch];
              chan_mode[ch]     <= M_RUN;
            end
            K_PET: chan_deadline[ch] <= cur.now + chan_timeout[ch];
            K_FORCE: best <= ch;
            K_ENABLE: pool_on <= 1'b1;
            K_DISABLE: begin
              if (pool_on) begin
                pool_on   <= 1'b0;
                last_tick <= cur.now;
              end
            end
            default: ;
          endcase
        end
      end
      if (cmd.scan_step) begin
        if (cand) begin
          found   <= 1'b1;
          best    <= idx;
          best_dl <= chan_deadline[idx];
        end
        if (!st.idx_last) idx <= idx + 1'b1;
      end
      if (cmd.scan_done) last_tick <= cur.now;
      if (cmd.shift_step) begin
        if (chan_mode[idx] == M_RUN)
          chan_deadline[idx] <= cur.now + (chan_deadline[idx] - last_tick);
        if (!st.idx_last) idx <= idx + 1'b1;
      end
      if (cmd.fire) chan_mode[best] <= M_DONE;
    end
  end

  always_comb begin
    res = '0;
    if (cmd.fire) begin
      res.status        = ST_OK;
      res.fired         = 1'b1;
      res.fired_channel = 4'(best);
      res.channel_mode  = M_DONE;
    end else begin
      res.status       = status;
      res.channel_mode = valid_ch ? m : M_IDLE;
      res.last         = 1'b1;
    end
  end
endmodule
`default_nettype wire

@@ sv/multi_channel_watchdog_pool_core.sv @@
// ----------------------------------------------------------------------------
// multi_channel_watchdog_pool_core
// Pool of watchdog channels driven by a command stream.
// ----------------------------------------------------------------------------
// Channel commands pass through the exec and final states; the final result
//   is loaded into the output register. Output stalls hold fire and final.
// Routine: one-channel-per-cycle deadline scan, a fire and fresh scan per
//   timed-out channel, then final. Enable: deadlines shifted, then final.
// One command in flight; next transfer taken once the final result is loaded.
// Reset (rst, synchronous) clears all channels, last tick and the pool enable.
`default_nettype none
module multi_channel_watchdog_pool_core
  import mcwd_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire       clk,
  input  wire       rst,
  input  wire       in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  wire       out_ready,
  output out_item_t out_data
);
  cmd_t      cmd;
  stat_t     st;
  out_item_t res;
  logic      out_load;
  logic      out_busy;

  // output register: holds a result until its transfer completes
  assign out_busy = out_valid && !out_ready;

  mcwd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_busy(out_busy), .out_load(out_load), .cmd(cmd), .st(st)
  );

  mcwd_dp #(.CHANNELS(CHANNELS)) u_dp (
    .clk(clk), .rst(rst), .in_item(in_data), .cmd(cmd), .st(st), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= res;
  end
endmodule
`default_nettype wire
